FILE: rtl/ebic_pkg.sv
// Shared types and constants for the encoder, button and idle controller.
// No dependencies; every other file imports this package.
package ebic_pkg;

    localparam int unsigned AddrWidth = 5;
    localparam int unsigned DataWidth = 32;

    localparam logic [2:0] REG_MENU_MIN      = 3'd0;
    localparam logic [2:0] REG_MENU_MAX      = 3'd1;
    localparam logic [2:0] REG_WRAP_ENABLE   = 3'd2;
    localparam logic [2:0] REG_SLEEP_ENABLE  = 3'd3;
    localparam logic [2:0] REG_SLEEP_TIMEOUT = 3'd4;

    localparam logic [3:0]  TURN_GAP      = 4'd8;
    localparam logic [3:0]  TURN_SAT      = 4'd9;
    localparam logic [9:0]  PRESS_GAP     = 10'd50;
    localparam logic [9:0]  LONG_TICKS    = 10'd800;
    localparam logic [31:0] TIMEOUT_RESET = 32'd15000;
    localparam logic [31:0] IDLE_MAX      = 32'hFFFF_FFFF;

    localparam logic [1:0] EVT_NONE  = 2'd0;
    localparam logic [1:0] EVT_CLICK = 2'd1;
    localparam logic [1:0] EVT_LONG  = 2'd2;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_ON   = 2'd1;
    localparam logic [1:0] CMD_OFF  = 2'd2;

    typedef struct packed {
        logic               clk_level;
        logic               dt_level;
        logic               switch_level;
        logic signed [15:0] current_index;
    } tick_t;

    typedef struct packed {
        logic signed [15:0] menu_index;
        logic [1:0]         button_event;
        logic [1:0]         display_command;
        logic               display_on;
    } result_t;

    typedef struct packed {
        logic signed [15:0] menu_min;
        logic signed [15:0] menu_max;
        logic               wrap_enable;
        logic               sleep_enable;
        logic [31:0]        sleep_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic        prev_clk;
        logic        prev_switch;
        logic [3:0]  turn_elapsed;
        logic [9:0]  press_elapsed;
        logic        long_reported;
        logic [31:0] idle_elapsed;
        logic        display_powered;
    } state_t;

    localparam state_t STATE_RESET = '{
        prev_clk:        1'b1,
        prev_switch:     1'b1,
        turn_elapsed:    4'd0,
        press_elapsed:   10'd0,
        long_reported:   1'b0,
        idle_elapsed:    32'd0,
        display_powered: 1'b1
    };

endpackage

FILE: rtl/ebic_regs.sv
// Configuration register bank behind the APB-style port.
// Depends on ebic_pkg for register indexes and the cfg_t struct.
module ebic_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ebic_pkg::AddrWidth-1:0]  paddr,
    input  logic [ebic_pkg::DataWidth-1:0]  pwdata,
    output logic [ebic_pkg::DataWidth-1:0]  prdata,
    output logic                            pready,
    output ebic_pkg::cfg_t                  cfg
);
    import ebic_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[AddrWidth-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.menu_min         <= 16'sd0;
            cfg_reg.menu_max         <= 16'sd0;
            cfg_reg.wrap_enable      <= 1'b0;
            cfg_reg.sleep_enable     <= 1'b0;
            cfg_reg.sleep_timeout_ms <= TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MENU_MIN:      cfg_reg.menu_min         <= $signed(pwdata[15:0]);
                REG_MENU_MAX:      cfg_reg.menu_max         <= $signed(pwdata[15:0]);
                REG_WRAP_ENABLE:   cfg_reg.wrap_enable      <= pwdata[0];
                REG_SLEEP_ENABLE:  cfg_reg.sleep_enable     <= pwdata[0];
                REG_SLEEP_TIMEOUT: cfg_reg.sleep_timeout_ms <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MENU_MIN:      prdata = {16'd0, cfg_reg.menu_min};
            REG_MENU_MAX:      prdata = {16'd0, cfg_reg.menu_max};
            REG_WRAP_ENABLE:   prdata = {31'd0, cfg_reg.wrap_enable};
            REG_SLEEP_ENABLE:  prdata = {31'd0, cfg_reg.sleep_enable};
            REG_SLEEP_TIMEOUT: prdata = cfg_reg.sleep_timeout_ms;
            default:           prdata = '0;
        endcase
    end

endmodule

FILE: rtl/ebic_tick.sv
// Single-tick update: encoder turn, button events and idle sleep.
// Purely combinational; depends on ebic_pkg for types and constants.
module ebic_tick
(
    input  ebic_pkg::tick_t   tick,
    input  ebic_pkg::cfg_t    cfg,
    input  ebic_pkg::state_t  state,
    output ebic_pkg::state_t  state_next,
    output ebic_pkg::result_t res
);
    import ebic_pkg::*;

    logic [3:0]         te;
    logic [9:0]         pe;
    logic [31:0]        ie;
    logic               turn;
    logic               press;
    logic               release_edge;
    logic               long_hit;
    logic               long_flag;
    logic               wake;
    logic               powered;
    logic signed [16:0] lo;
    logic signed [16:0] hi;
    logic signed [16:0] stepped;
    logic signed [16:0] wrap_a;
    logic signed [16:0] wrap_b;
    logic signed [16:0] clamped;
    logic signed [16:0] idx_sel;
    logic [1:0]         evt;
    logic [1:0]         cmd;

    assign lo = $signed({cfg.menu_min[15], cfg.menu_min});
    assign hi = $signed({cfg.menu_max[15], cfg.menu_max});

    always_comb
    begin
        te = (state.turn_elapsed < TURN_SAT) ? state.turn_elapsed + 4'd1
                                             : state.turn_elapsed;
        pe = (state.press_elapsed < LONG_TICKS) ? state.press_elapsed + 10'd1
                                                : state.press_elapsed;
        ie = (state.idle_elapsed != IDLE_MAX) ? state.idle_elapsed + 32'd1
                                              : state.idle_elapsed;

        // encoder
        turn = (tick.clk_level != state.prev_clk) && !tick.clk_level && (te > TURN_GAP);
        stepped = tick.dt_level
                ? $signed({tick.current_index[15], tick.current_index}) - 17'sd1
                : $signed({tick.current_index[15], tick.current_index}) + 17'sd1;
        wrap_a  = (stepped > hi) ? lo : stepped;
        wrap_b  = (wrap_a < lo) ? hi : wrap_a;
        clamped = (stepped < lo) ? lo : ((stepped > hi) ? hi : stepped);
        idx_sel = cfg.wrap_enable ? wrap_b : clamped;
        wake = 1'b0;
        if (turn)
        begin
            ie   = '0;
            te   = '0;
            wake = 1'b1;
        end

        // button
        long_flag = state.long_reported;
        evt       = EVT_NONE;
        press     = state.prev_switch && !tick.switch_level && (pe > PRESS_GAP);
        if (press)
        begin
            pe        = '0;
            long_flag = 1'b0;
            ie        = '0;
            wake      = 1'b1;
        end
        long_hit = !tick.switch_level && !long_flag && (pe >= LONG_TICKS);
        if (long_hit)
        begin
            evt       = EVT_LONG;
            long_flag = 1'b1;
        end
        release_edge = !state.prev_switch && tick.switch_level;
        if (release_edge)
        begin
            if (!long_flag && (pe > PRESS_GAP))
            begin
                evt = EVT_CLICK;
            end
            pe = '0;
        end

        // wake, then sleep
        powered = state.display_powered;
        cmd     = CMD_NONE;
        if (wake && !powered)
        begin
            powered = 1'b1;
            cmd     = CMD_ON;
        end
        if (cfg.sleep_enable && powered && (ie > cfg.sleep_timeout_ms))
        begin
            powered = 1'b0;
            cmd     = CMD_OFF;
        end

        state_next.prev_clk        = tick.clk_level;
        state_next.prev_switch     = tick.switch_level;
        state_next.turn_elapsed    = te;
        state_next.press_elapsed   = pe;
        state_next.long_reported   = long_flag;
        state_next.idle_elapsed    = ie;
        state_next.display_powered = powered;

        res.menu_index      = turn ? idx_sel[15:0] : tick.current_index;
        res.button_event    = evt;
        res.display_command = cmd;
        res.display_on      = powered;
    end

endmodule

FILE: rtl/encoder_button_idle_controller_top.sv
// Encoder, button and idle-sleep controller: request register, tick update,
// controller state and result register. Depends on ebic_pkg, ebic_regs, ebic_tick.
// Reset: asynchronous, clears both stages and loads the controller state reset values.
// A request waits in the request register until the result register is free, then is
// registered there; one request per cycle unless the result side stalls. Configuration
// writes take effect at once; users must make them with the pipeline empty, unchecked.
module encoder_button_idle_controller_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tick_valid,
    output logic                            tick_stall,
    input  ebic_pkg::tick_t                 tick,
    output logic                            res_valid,
    input  logic                            res_stall,
    output ebic_pkg::result_t               res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ebic_pkg::AddrWidth-1:0]  paddr,
    input  logic [ebic_pkg::DataWidth-1:0]  pwdata,
    output logic [ebic_pkg::DataWidth-1:0]  prdata,
    output logic                            pready
);
    import ebic_pkg::*;

    cfg_t    cfg;
    logic    s1_valid_reg;
    tick_t   s1_tick_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    res_valid_reg;
    logic    res_free;
    logic    advance;
    logic    tick_take;

    ebic_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ebic_tick u_tick
    (
        .tick       (s1_tick_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    assign res_free   = !res_valid_reg || !res_stall;
    assign advance    = s1_valid_reg && res_free;
    assign tick_stall = s1_valid_reg && !res_free;
    assign tick_take  = tick_valid && !tick_stall;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (tick_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            s1_tick_reg <= tick;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    a_cmd_on_powered: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.display_command == CMD_ON) |-> res.display_on)
        else $error("display on command with display off");

    a_cmd_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.display_command == CMD_OFF) |-> !res.display_on)
        else $error("display off command with display on");

    a_counters_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.turn_elapsed <= TURN_SAT) && (state_reg.press_elapsed <= LONG_TICKS))
        else $error("elapsed counter beyond saturation");

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.button_event != 2'd3) && (res.display_command != 2'd3))
        else $error("undefined event or command code");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        tick_take && s1_valid_reg |-> advance)
        else $error("request stage overwritten");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("controller state moved without a request");

endmodule

FILE: tb/ebic_result_checker.sv
// Result checker for the encoder, button and idle controller: follows the
// register port, request and result channels, predicts each result and compares.
// Depends on ebic_pkg for the request, result and register codes.
module ebic_result_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tick_valid,
    input  logic                           tick_stall,
    input  ebic_pkg::tick_t                tick,
    input  logic                           res_valid,
    input  logic                           res_stall,
    input  ebic_pkg::result_t              res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ebic_pkg::AddrWidth-1:0] paddr,
    input  logic [ebic_pkg::DataWidth-1:0] pwdata,
    input  logic                           pready,
    output int unsigned                    fail_count,
    output int unsigned                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import ebic_pkg::*;

    int          lo_bound;
    int          hi_bound;
    bit          wrap_on;
    bit          sleep_on;
    logic [31:0] sleep_after;

    logic        last_clk;
    logic        last_sw;
    logic [3:0]  since_turn;
    logic [9:0]  since_press;
    logic        long_seen;
    logic [31:0] since_activity;
    logic        screen_on;

    result_t     pending_results[$];
    result_t     want;
    int unsigned errors;

    assign fail_count = errors;

    function automatic result_t advance_tick(input tick_t t);
        result_t    r;
        int         idx;
        logic       wake;
        logic [1:0] evt;
        logic [1:0] cmd;
        idx  = t.current_index;
        wake = 1'b0;
        evt  = EVT_NONE;
        cmd  = CMD_NONE;
        if (since_turn < TURN_SAT)
            since_turn = since_turn + 4'd1;
        if (since_press < LONG_TICKS)
            since_press = since_press + 10'd1;
        if (since_activity != IDLE_MAX)
            since_activity = since_activity + 32'd1;

        if (t.clk_level != last_clk)
        begin
            if (!t.clk_level && since_turn > TURN_GAP)
            begin
                idx = t.dt_level ? idx - 1 : idx + 1;
                if (wrap_on)
                begin
                    if (idx > hi_bound)
                        idx = lo_bound;
                    if (idx < lo_bound)
                        idx = hi_bound;
                end
                else if (idx < lo_bound)
                    idx = lo_bound;
                else if (idx > hi_bound)
                    idx = hi_bound;
                since_activity = '0;
                wake           = 1'b1;
                since_turn     = '0;
            end
            last_clk = t.clk_level;
        end

        if (last_sw && !t.switch_level && since_press > PRESS_GAP)
        begin
            since_press    = '0;
            long_seen      = 1'b0;
            since_activity = '0;
            wake           = 1'b1;
        end
        if (!t.switch_level && !long_seen && since_press >= LONG_TICKS)
        begin
            evt       = EVT_LONG;
            long_seen = 1'b1;
        end
        if (!last_sw && t.switch_level)
        begin
            if (!long_seen && since_press > PRESS_GAP)
                evt = EVT_CLICK;
            since_press = '0;
        end
        last_sw = t.switch_level;

        if (wake && !screen_on)
        begin
            screen_on = 1'b1;
            cmd       = CMD_ON;
        end
        if (sleep_on && screen_on && since_activity > sleep_after)
        begin
            screen_on = 1'b0;
            cmd       = CMD_OFF;
        end

        r.menu_index      = idx[15:0];
        r.button_event    = evt;
        r.display_command = cmd;
        r.display_on      = screen_on;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic signed [31:0] exp_val,
                                 input logic signed [31:0] got_val);
        if (exp_val !== got_val)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_val, got_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_bound       = 0;
            hi_bound       = 0;
            wrap_on        = 1'b0;
            sleep_on       = 1'b0;
            sleep_after    = TIMEOUT_RESET;
            last_clk       = STATE_RESET.prev_clk;
            last_sw        = STATE_RESET.prev_switch;
            since_turn     = STATE_RESET.turn_elapsed;
            since_press    = STATE_RESET.press_elapsed;
            long_seen      = STATE_RESET.long_reported;
            since_activity = STATE_RESET.idle_elapsed;
            screen_on      = STATE_RESET.display_powered;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_MENU_MIN:      lo_bound    = $signed(pwdata[15:0]);
                    REG_MENU_MAX:      hi_bound    = $signed(pwdata[15:0]);
                    REG_WRAP_ENABLE:   wrap_on     = pwdata[0];
                    REG_SLEEP_ENABLE:  sleep_on    = pwdata[0];
                    REG_SLEEP_TIMEOUT: sleep_after = pwdata[31:0];
                    default: ;
                endcase
            end

            if (res_valid && !res_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with none expected, expected nothing, actual %p",
                             $time, res);
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("menu_index", want.menu_index, res.menu_index);
                    compare_field("button_event", want.button_event, res.button_event);
                    compare_field("display_command", want.display_command,
                                  res.display_command);
                    compare_field("display_on", want.display_on, res.display_on);
                end
            end

            if (tick_valid && !tick_stall)
                pending_results.push_back(advance_tick(tick));

            outstanding <= pending_results.size();
        end
    end

endmodule

FILE: tb/encoder_button_idle_controller_top_test.sv
// Stimulus and verdict for encoder_button_idle_controller_top: register setup,
// directed and random tick requests, random stalls. Depends on ebic_pkg and
// ebic_result_checker, which predicts and compares every result.
module encoder_button_idle_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ebic_pkg::*;

    localparam int HoldCycles = 200;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 tick_valid = 1'b0;
    logic                 tick_stall;
    tick_t                tick       = '0;
    logic                 res_valid;
    logic                 res_stall  = 1'b0;
    result_t              res;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [AddrWidth-1:0] paddr      = '0;
    logic [DataWidth-1:0] pwdata     = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;
    int unsigned          fail_count;
    int unsigned          outstanding;

    bit   no_idle      = 1'b0;
    bit   hold_results = 1'b0;
    cfg_t stim_cfg;
    logic gen_clk      = 1'b1;
    logic gen_sw       = 1'b1;
    int   clk_left     = 0;
    int   sw_left      = 0;
    int   clk_span     = 4;
    int   sw_span      = 60;
    int   noise_pct    = 0;

    encoder_button_idle_controller_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick       (tick),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    ebic_result_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_valid  (tick_valid),
        .tick_stall  (tick_stall),
        .tick        (tick),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // hold results for a long stretch when asked, else stall at random
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                res_stall <= 1'b1;
                repeat (HoldCycles) @(posedge clk);
                hold_results = 1'b0;
            end
            else
                res_stall <= !no_idle && ($urandom_range(99) < 38);
        end
    end

    function automatic cfg_t make_cfg(input int lo, input int hi, input bit wrap,
                                      input bit slp, input logic [31:0] tmo);
        cfg_t c;
        c.menu_min         = lo[15:0];
        c.menu_max         = hi[15:0];
        c.wrap_enable      = wrap;
        c.sleep_enable     = slp;
        c.sleep_timeout_ms = tmo;
        return c;
    endfunction

    function automatic tick_t make_tick(input bit c, input bit d, input bit s, input int idx);
        tick_t t;
        t.clk_level     = c;
        t.dt_level      = d;
        t.switch_level  = s;
        t.current_index = idx[15:0];
        return t;
    endfunction

    function automatic logic [15:0] pick_index();
        int          a;
        int          b;
        int unsigned r;
        int          v;
        a = stim_cfg.menu_min < stim_cfg.menu_max ? stim_cfg.menu_min : stim_cfg.menu_max;
        b = stim_cfg.menu_min < stim_cfg.menu_max ? stim_cfg.menu_max : stim_cfg.menu_min;
        r = $urandom_range(99);
        if (r < 15)
            v = int'($urandom);
        else if (r < 25)
            case ($urandom_range(3))
                0:       v = -32768;
                1:       v = 32767;
                2:       v = -32767;
                default: v = 32766;
            endcase
        else
            v = a - 2 + int'($urandom_range(b - a + 4 > 200 ? 200 : b - a + 4));
        return v[15:0];
    endfunction

    function automatic tick_t next_tick();
        tick_t t;
        if (clk_left == 0)
        begin
            gen_clk  = ~gen_clk;
            clk_left = int'($urandom_range(clk_span, 1));
        end
        else
            clk_left--;
        if (sw_left == 0)
        begin
            gen_sw  = ~gen_sw;
            sw_left = int'($urandom_range(sw_span, 1));
        end
        else
            sw_left--;
        t = make_tick(gen_clk, 1'($urandom_range(1)), gen_sw, 0);
        t.current_index = pick_index();
        if ($urandom_range(99) < noise_pct)
        begin
            t.clk_level    = 1'($urandom_range(1));
            t.switch_level = 1'($urandom_range(1));
        end
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        if (!no_idle)
        begin
            while ($urandom_range(99) < 38)
            begin
                tick_valid <= 1'b0;
                @(posedge clk);
            end
        end
        tick_valid <= 1'b1;
        tick       <= t;
        do @(posedge clk); while (tick_stall);
    endtask

    task automatic drain();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input cfg_t c);
        write_reg(REG_MENU_MIN, {{16{c.menu_min[15]}}, c.menu_min});
        write_reg(REG_MENU_MAX, {{16{c.menu_max[15]}}, c.menu_max});
        write_reg(REG_WRAP_ENABLE, {31'd0, c.wrap_enable});
        write_reg(REG_SLEEP_ENABLE, {31'd0, c.sleep_enable});
        write_reg(REG_SLEEP_TIMEOUT, c.sleep_timeout_ms);
        stim_cfg = c;
    endtask

    task automatic run_phase(input cfg_t c, input int count, input int cspan,
                             input int sspan, input int noise);
        drain();
        set_config(c);
        clk_span  = cspan;
        sw_span   = sspan;
        noise_pct = noise;
        repeat (count) send_tick(next_tick());
    endtask

    initial
    begin
        wait (rst_n);
        @(posedge clk);

        // full range with wrap and a short timeout: sleep, wrap at both ends,
        // turn inside the gap, press bounce
        drain();
        set_config(make_cfg(-32768, 32767, 1'b1, 1'b1, 32'd3));
        repeat (9) send_tick(make_tick(1'b1, 1'b0, 1'b1, 0));
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 32767));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 5));
        send_tick(make_tick(1'b0, 1'b1, 1'b1, 0));
        repeat (8) send_tick(make_tick(1'b1, 1'b0, 1'b1, -1));
        send_tick(make_tick(1'b0, 1'b1, 1'b1, -32768));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, -32768));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 32767));

        drain();
        hold_results = 1'b1;
        run_phase(make_cfg(-5, 5, 1'b0, 1'b1, 32'd20), 300, 6, 80, 8);
        run_phase(make_cfg(-5, 5, 1'b1, 1'b1, 32'd0), 200, 3, 30, 15);
        no_idle = 1'b1;
        run_phase(make_cfg(3, -3, 1'b1, 1'b0, TIMEOUT_RESET), 200, 5, 70, 10);
        no_idle = 1'b0;
        run_phase(make_cfg(3, -3, 1'b0, 1'b1, 32'd1), 200, 25, 120, 5);
        gen_sw  = 1'b0;
        sw_left = 820;
        run_phase(make_cfg(-32768, 32767, 1'b0, 1'b1, 32'hFFFF_FFFF), 830, 10, 60, 0);
        run_phase(make_cfg(0, 0, 1'b1, 1'b1, 32'd40), 150, 40, 100, 5);

        drain();
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: encoder_button_idle_controller_top.f
rtl/ebic_pkg.sv
rtl/ebic_regs.sv
rtl/ebic_tick.sv
rtl/encoder_button_idle_controller_top.sv
tb/ebic_result_checker.sv
tb/encoder_button_idle_controller_top_test.sv
